// ===== rtl/tcp_passive_connection_fsm_defines.svh =====
// ----------------------------------------------------------------------------
// TCP passive connection FSM - assertion macros
// Concurrent assertion helpers shared by the RTL files of the block.
// ----------------------------------------------------------------------------
`ifndef TCP_PASSIVE_CONNECTION_FSM_DEFINES_SVH
`define TCP_PASSIVE_CONNECTION_FSM_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define TCP_PCF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define TCP_PCF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`else

`define TCP_PCF_ASSERT(lbl, clk, rst_n, prop, msg)
`define TCP_PCF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/tcp_pcf_pkg.sv =====
// ----------------------------------------------------------------------------
// TCP passive connection FSM - package
// Header record types, state encoding, flag masks and register reset values.
// ----------------------------------------------------------------------------
package tcp_pcf_pkg;

  typedef enum logic [1:0] {
    ST_LISTEN  = 2'd0,
    ST_SYNRCVD = 2'd1,
    ST_ESTAB   = 2'd2
  } conn_state_e;

  typedef enum logic [1:0] {
    CFG_LISTEN_PORT = 2'd0,
    CFG_INIT_SEQ    = 2'd1,
    CFG_RECV_WINDOW = 2'd2
  } cfg_idx_e;

  localparam logic [7:0] FlagSyn = 8'h02;
  localparam logic [7:0] FlagRst = 8'h04;
  localparam logic [7:0] FlagAck = 8'h10;

  localparam logic [15:0] ListenPortRst  = 16'd8000;
  localparam logic [31:0] InitSendSeqRst = 32'd312;
  localparam logic [15:0] RecvWindowRst  = 16'd200;

  localparam int CfgDataW = 32;

  // Received header, first field in the lowest bits.
  typedef struct packed {
    logic [15:0] segment_length;
    logic [15:0] peer_window;
    logic [7:0]  seg_flags;
    logic [3:0]  data_offset;
    logic [31:0] ack_no;
    logic [31:0] seq_no;
    logic [15:0] dst_port;
    logic [15:0] src_port;
  } seg_hdr_t;

  // Reply header, first field in the lowest bits.
  typedef struct packed {
    conn_state_e conn_state_out;
    logic [15:0] echo_length;
    logic [15:0] reply_window;
    logic [7:0]  reply_flags;
    logic [31:0] reply_ack;
    logic [31:0] reply_seq;
    logic [15:0] reply_dst_port;
    logic [15:0] reply_src_port;
  } reply_hdr_t;

  typedef struct packed {
    logic [15:0] listen_port;
    logic [31:0] initial_send_seq;
    logic [15:0] receive_window;
  } cfg_t;

  localparam int SegW     = $bits(seg_hdr_t);
  localparam int ReplyW   = $bits(reply_hdr_t);
  localparam int InTdataW  = ((SegW + 7) / 8) * 8;
  localparam int OutTdataW = ((ReplyW + 7) / 8) * 8;

endpackage

// ===== rtl/tcp_pcf_engine.sv =====
// ----------------------------------------------------------------------------
// TCP passive connection FSM - connection engine
// Holds the connection record and decides the reply for one segment.
// ----------------------------------------------------------------------------
`include "tcp_passive_connection_fsm_defines.svh"

module tcp_pcf_engine
  import tcp_pcf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  seg_hdr_t   seg_i,
  input  cfg_t       cfg_i,
  output logic       has_reply_o,
  output reply_hdr_t reply_o
);

  conn_state_e conn_state_q, conn_state_d;
  logic [15:0] peer_port_q, peer_port_d;
  logic [31:0] send_unacked_q, send_unacked_d;
  logic [31:0] send_next_q, send_next_d;
  logic [15:0] send_window_q, send_window_d;
  logic [31:0] recv_next_q, recv_next_d;
  logic [31:0] initial_recv_seq_q, initial_recv_seq_d;

  logic [5:0]  hdr_len;
  logic [15:0] dlen;
  logic        foreign;
  logic        f_syn, f_rst, f_ack;

  assign hdr_len = {seg_i.data_offset, 2'b00};
  assign dlen    = (seg_i.segment_length > {10'd0, hdr_len}) ?
                   (seg_i.segment_length - {10'd0, hdr_len}) : 16'd0;
  assign foreign = (seg_i.dst_port != cfg_i.listen_port);
  assign f_syn   = |(seg_i.seg_flags & FlagSyn);
  assign f_rst   = |(seg_i.seg_flags & FlagRst);
  assign f_ack   = |(seg_i.seg_flags & FlagAck);

  // Next-state logic for the connection record.
  always_comb begin
    conn_state_d       = conn_state_q;
    peer_port_d        = peer_port_q;
    send_unacked_d     = send_unacked_q;
    send_next_d        = send_next_q;
    send_window_d      = send_window_q;
    recv_next_d        = recv_next_q;
    initial_recv_seq_d = initial_recv_seq_q;
    if (adv_i && !foreign) begin
      unique case (conn_state_q)
        ST_LISTEN: begin
          if (!f_rst) begin
            if (f_ack) begin
              send_next_d = seg_i.ack_no;
            end else if (f_syn) begin
              conn_state_d       = ST_SYNRCVD;
              peer_port_d        = seg_i.src_port;
              initial_recv_seq_d = seg_i.seq_no;
              recv_next_d        = seg_i.seq_no + 32'd1;
              send_window_d      = seg_i.peer_window;
              send_unacked_d     = cfg_i.initial_send_seq;
              send_next_d        = cfg_i.initial_send_seq + 32'd1;
            end
          end
        end
        ST_SYNRCVD: begin
          if (f_rst) begin
            conn_state_d = ST_LISTEN;
          end else if (f_ack) begin
            conn_state_d = ST_ESTAB;
          end
        end
        ST_ESTAB: begin
          if (f_rst) begin
            conn_state_d = ST_LISTEN;
          end else begin
            if (f_ack) begin
              send_unacked_d = seg_i.ack_no;
              recv_next_d    = seg_i.seq_no + {16'd0, dlen};
            end
            send_next_d = send_next_q + {16'd0, dlen};
          end
        end
        default: begin
          conn_state_d = conn_state_q;
        end
      endcase
    end
  end

  // Reply header for the segment in flight.
  always_comb begin
    has_reply_o                = 1'b0;
    reply_o.reply_src_port     = cfg_i.listen_port;
    reply_o.reply_dst_port     = seg_i.src_port;
    reply_o.reply_seq          = '0;
    reply_o.reply_ack          = '0;
    reply_o.reply_flags        = '0;
    reply_o.reply_window       = cfg_i.receive_window;
    reply_o.echo_length        = '0;
    reply_o.conn_state_out     = conn_state_d;
    if (foreign) begin
      // No connection on that port: reset back to the sender.
      has_reply_o            = 1'b1;
      reply_o.reply_src_port = seg_i.dst_port;
      if (f_ack) begin
        reply_o.reply_seq   = seg_i.ack_no;
        reply_o.reply_flags = FlagRst;
      end else begin
        reply_o.reply_ack   = seg_i.seq_no + {16'd0, dlen};
        reply_o.reply_flags = FlagRst | FlagAck;
      end
    end else begin
      unique case (conn_state_q)
        ST_LISTEN: begin
          if (!f_rst && f_ack) begin
            has_reply_o         = 1'b1;
            reply_o.reply_seq   = seg_i.ack_no;
            reply_o.reply_ack   = recv_next_q;
            reply_o.reply_flags = FlagRst;
          end else if (!f_rst && f_syn) begin
            has_reply_o         = 1'b1;
            reply_o.reply_seq   = cfg_i.initial_send_seq;
            reply_o.reply_ack   = seg_i.seq_no + 32'd1;
            reply_o.reply_flags = FlagSyn | FlagAck;
          end
        end
        ST_SYNRCVD: begin
          has_reply_o = 1'b0;
        end
        ST_ESTAB: begin
          if (!f_rst) begin
            has_reply_o            = 1'b1;
            reply_o.reply_dst_port = peer_port_q;
            reply_o.reply_seq      = send_next_q;
            reply_o.reply_ack      = recv_next_d;
            reply_o.reply_flags    = FlagAck;
            reply_o.echo_length    = dlen;
          end
        end
        default: begin
          has_reply_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conn_state_q       <= ST_LISTEN;
      peer_port_q        <= '0;
      send_unacked_q     <= '0;
      send_next_q        <= '0;
      send_window_q      <= '0;
      recv_next_q        <= '0;
      initial_recv_seq_q <= '0;
    end else begin
      conn_state_q       <= conn_state_d;
      peer_port_q        <= peer_port_d;
      send_unacked_q     <= send_unacked_d;
      send_next_q        <= send_next_d;
      send_window_q      <= send_window_d;
      recv_next_q        <= recv_next_d;
      initial_recv_seq_q <= initial_recv_seq_d;
    end
  end

  `TCP_PCF_ASSERT(a_state_moves_on_adv, clk_i, rst_ni,
    $stable(conn_state_q) || $past(adv_i), "connection state changed without a segment")
  `TCP_PCF_ASSERT(a_snd_nxt_moves_on_adv, clk_i, rst_ni,
    $stable(send_next_q) || $past(adv_i), "send_next changed without a segment")
  `TCP_PCF_ASSERT_IMP(a_syn_gets_synack, clk_i, rst_ni,
    adv_i && conn_state_q == ST_LISTEN && conn_state_d == ST_SYNRCVD,
    has_reply_o && reply_o.reply_flags == (FlagSyn | FlagAck),
    "entering syn-received without a SYN+ACK reply")

endmodule

// ===== rtl/tcp_passive_connection_fsm.sv =====
// ----------------------------------------------------------------------------
// TCP passive connection FSM - top level
// Single passive TCP connection: takes decoded segment headers, gives replies.
// ----------------------------------------------------------------------------
// The block takes one decoded TCP header per transfer and returns at most one
// reply header per segment, in order. It sustains one segment per clock cycle
// while the output register does not hold a reply that is not taken: a segment
// is held in the input register, where the connection record is read and
// updated in a single pass, and its reply, if any, is loaded into the output
// register when the segment advances, so a reply passes through the input and
// output registers before it is presented. The flow stalls only while the
// output register holds a reply that is not taken.
// Segments for other ports get a reset; a SYN in listen is answered with
// SYN+ACK; data in established is echoed with an ACK. Write the configuration
// registers (0 listen port, 1 initial send sequence, 2 receive window) only
// while no segment is in flight.
// ----------------------------------------------------------------------------
`include "tcp_passive_connection_fsm_defines.svh"

module tcp_passive_connection_fsm
  import tcp_pcf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  // Segment header input
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // src_port, dst_port, seq_no, ack_no, data_offset, seg_flags, peer_window,
  // segment_length, zero pad
  input  logic [InTdataW-1:0]  s_axis_tdata,
  // Reply header output
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // reply_src_port, reply_dst_port, reply_seq, reply_ack, reply_flags,
  // reply_window, echo_length, conn_state_out, zero pad
  output logic [OutTdataW-1:0] m_axis_tdata
);

  cfg_t       cfg_q;
  logic       in_valid_q;
  seg_hdr_t   in_q;
  logic       out_valid_q;
  reply_hdr_t out_q;
  logic       adv;
  logic       has_reply;
  reply_hdr_t reply;
  logic       load;

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.listen_port      <= ListenPortRst;
      cfg_q.initial_send_seq <= InitSendSeqRst;
      cfg_q.receive_window   <= RecvWindowRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LISTEN_PORT: cfg_q.listen_port      <= cfg_data_i[15:0];
        CFG_INIT_SEQ:    cfg_q.initial_send_seq <= cfg_data_i[31:0];
        CFG_RECV_WINDOW: cfg_q.receive_window   <= cfg_data_i[15:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // Advance the held segment whenever the reply slot is free or draining.
  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign load          = adv && has_reply;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= s_axis_tdata[SegW-1:0];
    end
  end

  tcp_pcf_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .seg_i       (in_q),
    .cfg_i       (cfg_q),
    .has_reply_o (has_reply),
    .reply_o     (reply)
  );

  // Reply register: load a new reply, otherwise drop the one just taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= reply;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutTdataW - ReplyW){1'b0}}, out_q};

  `TCP_PCF_ASSERT_IMP(a_stall_only_when_full, clk_i, rst_ni,
    !s_axis_tready, in_valid_q && out_valid_q && !m_axis_tready,
    "input stalled while the pipeline can advance")
  `TCP_PCF_ASSERT_IMP(a_foreign_port_reset, clk_i, rst_ni,
    adv && in_q.dst_port != cfg_q.listen_port, has_reply,
    "segment for another port got no reset reply")
  `TCP_PCF_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni,
    out_valid_q && !m_axis_tready, !load,
    "pending reply overwritten")

endmodule
